FILE: rtl/core/saria_pkg.sv
// shared constants, codes and types for the sorted array insert/remove unit
package saria_pkg;

  localparam int CAPACITY = 16;
  localparam int OCC_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int CMD_W    = 2;
  localparam int ST_W     = 2;
  localparam int CNT_W    = 5;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [ST_W-1:0] ST_DONE     = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

  typedef logic signed [VAL_W-1:0] value_t;

  // write strobes broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctl_t;

endpackage

FILE: rtl/core/saria_cell.sv
// one storage cell of the sorted chain: compares against the key and shifts with neighbors
module saria_cell (
  input  logic                clk,
  input  saria_pkg::cell_ctl_t ctl,
  input  saria_pkg::value_t   key,
  input  logic                occupied,
  input  logic                lo_ins_here,
  input  saria_pkg::value_t   lo_entry,
  input  saria_pkg::value_t   hi_entry,
  output saria_pkg::value_t   entry,
  output logic                ins_here,
  output logic                match
);

  saria_pkg::value_t entry_r;
  saria_pkg::value_t entry_nxt;
  logic              ge;

  assign ge       = occupied && (entry_r >= key);
  // unoccupied cell or entry not below the key: insertion point or beyond
  assign ins_here = !occupied || ge;
  assign match    = occupied && (entry_r == key);
  assign entry    = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins && ins_here) begin
      entry_nxt = lo_ins_here ? lo_entry : key;
    end else if (ctl.rem && ge) begin
      // every occupied cell at or after the first match pulls from above
      entry_nxt = hi_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

FILE: rtl/core/sorted_array_insert_remove_unit.sv
// Sorted array of signed 32-bit values kept as a chain of compare-and-shift cells.
// Every cell compares its entry with the command value in parallel and takes its own
// word, its lower or upper neighbor's word or the command value; insert, remove and
// clear take effect at the accepting edge. One command is accepted per cycle while
// the result register is free or being drained. Each command yields one result item
// with a status and the new count. Capacity is saria_pkg::CAPACITY; a full insert or
// a missing value leaves the array unchanged. No clearing pass is needed after reset.
module sorted_array_insert_remove_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [4:0] count, [7:5] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int N = saria_pkg::CAPACITY;

  logic [saria_pkg::OCC_W-1:0] occ_r, occ_nxt;
  logic                        out_valid_r;
  logic [saria_pkg::ST_W-1:0]  status_r, status_nxt;
  logic [saria_pkg::CNT_W-1:0] count_r;

  saria_pkg::cell_ctl_t ctl;
  saria_pkg::value_t    key;
  saria_pkg::value_t    entries [N];
  logic [N-1:0]         ins_vec;
  logic [N-1:0]         match_vec;
  logic                 accept;
  logic                 full;
  logic                 empty;
  logic                 found;

  assign key       = $signed(in_tdata);
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign full      = (occ_r == saria_pkg::OCC_W'(N));
  assign empty     = (occ_r == '0);
  assign found     = |match_vec;

  always_comb begin
    occ_nxt    = occ_r;
    status_nxt = saria_pkg::ST_DONE;
    ctl        = '0;
    unique case (in_tuser)
      saria_pkg::CMD_INSERT: begin
        if (full) begin
          status_nxt = saria_pkg::ST_FULL;
        end else begin
          ctl.ins = accept;
          occ_nxt = occ_r + 1'b1;
        end
      end
      saria_pkg::CMD_REMOVE: begin
        if (empty) begin
          status_nxt = saria_pkg::ST_EMPTY;
        end else if (!found) begin
          status_nxt = saria_pkg::ST_NOTFOUND;
        end else begin
          ctl.rem = accept;
          occ_nxt = occ_r - 1'b1;
        end
      end
      saria_pkg::CMD_CLEAR: begin
        occ_nxt = '0;
      end
      default: begin
        occ_nxt = occ_r;
      end
    endcase
  end

  genvar gi;
  generate
    for (gi = 0; gi < N; gi++) begin : g_cell
      logic              lo_ins;
      saria_pkg::value_t lo_ent;
      saria_pkg::value_t hi_ent;

      if (gi == 0) begin : g_lo_edge
        assign lo_ins = 1'b0;
        assign lo_ent = key;
      end else begin : g_lo
        assign lo_ins = ins_vec[gi-1];
        assign lo_ent = entries[gi-1];
      end

      if (gi == N - 1) begin : g_hi_edge
        assign hi_ent = entries[gi];
      end else begin : g_hi
        assign hi_ent = entries[gi+1];
      end

      saria_cell u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .key         (key),
        .occupied    (saria_pkg::OCC_W'(gi) < occ_r),
        .lo_ins_here (lo_ins),
        .lo_entry    (lo_ent),
        .hi_entry    (hi_ent),
        .entry       (entries[gi]),
        .ins_here    (ins_vec[gi]),
        .match       (match_vec[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        occ_r       <= occ_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      count_r  <= saria_pkg::CNT_W'(occ_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {3'b000, count_r};

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= saria_pkg::OCC_W'(N))
    else $error("occupancy above capacity");

  // sorted contents: the insertion boundary rises at most once along the chain
  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(ins_vec & ~{ins_vec[N-2:0], 1'b0}))
    else $error("chain not in ascending order");

  a_rem_dec: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.rem |=> occ_r == $past(occ_r) - 1'b1)
    else $error("remove did not shrink occupancy");

  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tuser == saria_pkg::CMD_INSERT && full) |=> $stable(occ_r))
    else $error("full insert changed occupancy");

  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_tvalid && out_tdata[4:0] == saria_pkg::CNT_W'(occ_r))
    else $error("result missing or count mismatch");
`endif

endmodule
